// File: hw/rtl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared constants and controller/datapath interface types for the Sobel
// gradient magnitude unit.
// ----------------------------------------------------------------------------
package sgm_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int PIX_W  = 8;
   localparam int FW_W   = 11;
   localparam int FH_W   = 13;
   localparam int GRAD_W = 10;
   localparam int SQ_W   = 2 * GRAD_W + 1;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(500);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(800);
   localparam logic [FW_W-1:0] FRAME_WIDTH_MIN    = FW_W'(3);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_MIN   = FH_W'(3);
   localparam logic [FW_W-1:0] FRAME_WIDTH_MAX    = FW_W'(MAX_WIDTH);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_MAX   = FH_W'(MAX_HEIGHT);

   localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

   typedef struct packed {
      logic capture;    // latch pixel, read both line stores
      logic advance;    // write line stores, shift window, step position
      logic square;     // form gx^2 + gy^2, arm the root search
      logic root_step;  // one bit of the root search
      logic load_out;   // move the finished result into the output register
      logic restart;    // return to the first pixel of a frame
   } sgm_cmd_type;

   typedef struct packed {
      logic interior;   // current position produces a result
      logic root_last;  // root search is on its last bit
   } sgm_status_type;

endpackage

// File: hw/rtl/sobel_gradient_magnitude_unit.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_unit
// Streaming 3x3 Sobel gradient magnitude over a raster pixel stream, with
// frame size registers, two line stores and a saturated integer root.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_pixel
//   rsp      out        rsp_valid, rsp_ready, rsp_magnitude, rsp_centre_row,
//                       rsp_centre_col, rsp_frame_last
//   csr      in         csr_valid, csr_ready, csr_index, csr_wdata
//
// A border pixel takes a capture with line store read, then a window
// update; an interior pixel then adds one squaring step and the 8-bit
// bit-serial square root. One item is in flight at a time.
// A finished result waits in the output register while the next pixel is
// taken; a stalled rsp channel blocks only when a second result is ready.
// Reset sets width 500, height 800 and restarts the frame; a csr write to
// either register also restarts the frame. The csr port is always ready.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_unit
   import sgm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_W-1:0]       req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIX_W-1:0]       rsp_magnitude,
   output logic [ROW_W-1:0]       rsp_centre_row,
   output logic [COL_W-1:0]       rsp_centre_col,
   output logic                   rsp_frame_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [FW_W-1:0]  frame_width_ff, frame_width_in;
   logic [FH_W-1:0]  frame_height_ff, frame_height_in;
   logic [COL_W-1:0] width_last;
   logic [ROW_W-1:0] height_last;
   logic             csr_write;
   logic             cfg_write;
   sgm_cmd_type      cmd;
   sgm_status_type   status;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign cfg_write = csr_write &&
                      ((csr_index == REG_FRAME_WIDTH) || (csr_index == REG_FRAME_HEIGHT));

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write && (csr_index == REG_FRAME_WIDTH)) begin
         frame_width_in = csr_wdata[FW_W-1:0];
      end
      if (csr_write && (csr_index == REG_FRAME_HEIGHT)) begin
         frame_height_in = csr_wdata[FH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // clamp to the supported frame size, then take the last index
   always_comb begin
      priority if (frame_width_ff < FRAME_WIDTH_MIN) begin
         width_last = COL_W'(FRAME_WIDTH_MIN - 1'b1);
      end else if (frame_width_ff > FRAME_WIDTH_MAX) begin
         width_last = COL_W'(FRAME_WIDTH_MAX - 1'b1);
      end else begin
         width_last = COL_W'(frame_width_ff - 1'b1);
      end
   end

   always_comb begin
      priority if (frame_height_ff < FRAME_HEIGHT_MIN) begin
         height_last = ROW_W'(FRAME_HEIGHT_MIN - 1'b1);
      end else if (frame_height_ff > FRAME_HEIGHT_MAX) begin
         height_last = ROW_W'(FRAME_HEIGHT_MAX - 1'b1);
      end else begin
         height_last = ROW_W'(frame_height_ff - 1'b1);
      end
   end

   sgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cfg_write (cfg_write),
      .status    (status),
      .cmd       (cmd)
   );

   sgm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_pixel      (req_pixel),
      .width_last     (width_last),
      .height_last    (height_last),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_centre_row (rsp_centre_row),
      .rsp_centre_col (rsp_centre_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// File: hw/rtl/sgm_ctrl.sv
// ----------------------------------------------------------------------------
// sgm_ctrl
// Sequencer: accepts one pixel and walks it through the window update;
// an interior pixel then goes through the squaring step and the
// bit-serial root, and its result is handed to the output register.
// ----------------------------------------------------------------------------
module sgm_ctrl
   import sgm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  logic           cfg_write,
   input  sgm_status_type status,
   output sgm_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CALC   = 3'd1;
   localparam logic [2:0] ST_SQUARE = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.restart = cfg_write;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.advance = 1'b1;
            state_in    = status.interior ? ST_SQUARE : ST_IDLE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold the result until the output register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/sgm_datapath.sv
// ----------------------------------------------------------------------------
// sgm_datapath
// Line stores, 3x3 window, frame position, Sobel sums, squaring and the
// bit-serial square root, plus the result registers.
// ----------------------------------------------------------------------------
module sgm_datapath
   import sgm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sgm_cmd_type       cmd,
   output sgm_status_type    status,
   input  logic [PIX_W-1:0]  req_pixel,
   input  logic [COL_W-1:0]  width_last,
   input  logic [ROW_W-1:0]  height_last,
   output logic [PIX_W-1:0]  rsp_magnitude,
   output logic [ROW_W-1:0]  rsp_centre_row,
   output logic [COL_W-1:0]  rsp_centre_col,
   output logic              rsp_frame_last
);

   logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   logic [PIX_W-1:0] pixel_ff;
   logic [PIX_W-1:0] top_ff;
   logic [PIX_W-1:0] mid_ff;
   logic [PIX_W-1:0] win_ff [6];

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   logic [ROW_W-1:0] cen_row_ff;
   logic [COL_W-1:0] cen_col_ff;
   logic             cen_last_ff;

   logic [GRAD_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
   logic [GRAD_W-1:0] gx_abs, gy_abs;
   logic [GRAD_W-1:0] gx_abs_ff, gy_abs_ff;
   logic [2*GRAD_W-1:0] gx_sq, gy_sq;
   logic [SQ_W-1:0]   sum_ff;

   logic [PIX_W-1:0]   root_ff, root_bit_ff, root_trial;
   logic [2*PIX_W-1:0] trial_sq;

   logic [PIX_W-1:0] mag_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic [COL_W-1:0] out_col_ff;
   logic             out_last_ff;

   // line stores: read on capture, write back on advance
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         top_ff <= upper_mem[col_ff];
      end
      if (cmd.advance) begin
         upper_mem[col_ff] <= mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mid_ff <= middle_mem[col_ff];
      end
      if (cmd.advance) begin
         middle_mem[col_ff] <= pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pixel_ff <= req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_ff;
         win_ff[4] <= mid_ff;
         win_ff[5] <= pixel_ff;
      end
   end

   // raster position
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.restart) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.advance) begin
         if (col_ff == width_last) begin
            col_in = '0;
            row_in = (row_ff == height_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign status.interior = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));

   // Sobel sums; window columns are c-2 (0..2) and c-1 (3..5), top to bottom
   assign gx_pos = {2'b00, top_ff} + {1'b0, mid_ff, 1'b0} + {2'b00, pixel_ff};
   assign gx_neg = {2'b00, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b00, win_ff[2]};
   assign gy_pos = {2'b00, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b00, pixel_ff};
   assign gy_neg = {2'b00, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b00, top_ff};
   assign gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
   assign gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;

   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         gx_abs_ff   <= gx_abs;
         gy_abs_ff   <= gy_abs;
         cen_row_ff  <= row_ff - 1'b1;
         cen_col_ff  <= col_ff - 1'b1;
         cen_last_ff <= (row_ff == height_last) && (col_ff == width_last);
      end
   end

   assign gx_sq = gx_abs_ff * gx_abs_ff;
   assign gy_sq = gy_abs_ff * gy_abs_ff;

   // bit-serial root, most significant bit first
   assign root_trial = root_ff | root_bit_ff;
   assign trial_sq   = root_trial * root_trial;
   assign status.root_last = root_bit_ff[0];

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sum_ff      <= {1'b0, gx_sq} + {1'b0, gy_sq};
         root_ff     <= '0;
         root_bit_ff <= {1'b1, {(PIX_W-1){1'b0}}};
      end else if (cmd.root_step) begin
         if (trial_sq <= sum_ff[2*PIX_W-1:0]) begin
            root_ff <= root_trial;
         end
         root_bit_ff <= root_bit_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         // saturate once the sum reaches 2^16
         mag_ff      <= (|sum_ff[SQ_W-1:2*PIX_W]) ? MAG_MAX : root_ff;
         out_row_ff  <= cen_row_ff;
         out_col_ff  <= cen_col_ff;
         out_last_ff <= cen_last_ff;
      end
   end

   assign rsp_magnitude  = mag_ff;
   assign rsp_centre_row = out_row_ff;
   assign rsp_centre_col = out_col_ff;
   assign rsp_frame_last = out_last_ff;

endmodule
